// ----- rtl/gain_and_tail_cancellation_filter_defines.svh -----
// ----------------------------------------------------------------------------
// Gain and tail cancellation filter: assertion macros
// Short forms for same-cycle and next-cycle implications on clk, reset by rst.
// ----------------------------------------------------------------------------
`ifndef GAIN_AND_TAIL_CANCELLATION_FILTER_DEFINES_SVH
`define GAIN_AND_TAIL_CANCELLATION_FILTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gtc_pkg.sv -----
// ----------------------------------------------------------------------------
// gtc_pkg
// Constants and types of the gain and tail cancellation filter.
// ----------------------------------------------------------------------------
package gtc_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_TAIL_ENABLE = 2'd0;
  localparam logic [1:0] REG_EXP_COUNT   = 2'd1;
  localparam logic [1:0] REG_THRESHOLD   = 2'd2;

  // fixed point layout
  localparam int DIV_SHIFT = 20;  // sample << 20 before the divide
  localparam int QBITS     = 18;  // quotient bits, saturates at 2^18-1
  localparam int AMP_BITS  = 19;
  localparam int THR_BITS  = 10;
  localparam int GAIN_BITS = 16;

  // sequencing
  localparam int DIV_STEPS = QBITS;
  localparam int MUL_STEPS = 8;   // 16-bit constant, 2-bit digits
  localparam int CNT_BITS  = 5;

  // Q0.16 rates and coefficients
  localparam logic [15:0] RATE_FAST = 16'd60105;
  localparam logic [15:0] RATE_SLOW = 16'd30367;
  localparam logic [15:0] COEF_ONE  = 16'd4325;
  localparam logic [15:0] COEF_FAST = 16'd7471;
  localparam logic [15:0] COEF_SLOW = 16'd40894;

  localparam bit LANE_FAST = 1'b0;
  localparam bit LANE_SLOW = 1'b1;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DIV   = 12'b0000_0000_0010,
    ST_SUM   = 12'b0000_0000_0100,
    ST_CORR  = 12'b0000_0000_1000,
    ST_PREP1 = 12'b0000_0001_0000,
    ST_MUL1  = 12'b0000_0010_0000,
    ST_RND1  = 12'b0000_0100_0000,
    ST_ADDS  = 12'b0000_1000_0000,
    ST_PREP2 = 12'b0001_0000_0000,
    ST_MUL2  = 12'b0010_0000_0000,
    ST_WB    = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

endpackage

// ----- rtl/gain_and_tail_cancellation_filter.sv -----
// Steps: accept, bit-serial divide (1 bit/cycle), sum, correct; with the
//   filter on, two radix-4 serial multiplies and a write-back; then hand
//   over. A zero or saturating gain skips the divide. One word at a time:
//   a new word is accepted only after the last is handed to the output.
// Reset (rst, synchronous): sequencer idle, output empty, remainders zero,
//   tail cancel on, two exponentials, threshold zero.
// ----------------------------------------------------------------------------
// gain_and_tail_cancellation_filter
// Gain correction by serial divide, then optional one- or two-exponential
// tail cancellation on two multiplier lanes, then thresholding.
// ----------------------------------------------------------------------------
module gain_and_tail_cancellation_filter import gtc_pkg::*; #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [THR_BITS-1:0]           cfg_data,
  // input words
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [SAMPLE_BITS-1:0]        adc_sample,
  input  logic [GAIN_BITS-1:0]          pad_gain,
  input  logic                          series_start,
  // result words
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [AMP_BITS-1:0]    amplitude,
  output logic                          above_threshold,
  output logic                          gain_invalid
);

  localparam int NW   = SAMPLE_BITS + DIV_SHIFT + 1;
  localparam int HW   = NW - QBITS;
  localparam int CMPW = SAMPLE_BITS + 17;

  // configuration registers
  logic                tail_enable;
  logic [1:0]          exp_count;
  logic [THR_BITS-1:0] threshold;

  state_t               state;
  logic [CNT_BITS-1:0]  cnt;
  logic [GAIN_BITS-1:0] gain_q;
  logic                 invalid_q;
  logic [15:0]          div_rem;
  logic [QBITS-1:0]     div_low;   // dividend bits in, quotient bits out
  logic signed [33:0]   corr_q;
  logic signed [AMP_BITS-1:0] r_q;

  // per-lane registers
  logic signed [31:0] rem    [2];
  logic signed [32:0] mcand  [2];
  logic signed [34:0] m3     [2];
  logic signed [48:0] acc    [2];
  logic [15:0]        dig    [2];

  logic filter_on, two_exp;
  assign two_exp   = exp_count[1];
  assign filter_on = tail_enable && (exp_count != 2'd0);

  // dividend and overflow check at accept
  logic [NW-1:0] dividend;
  logic [HW-1:0] div_hi;
  logic          div_ovf;
  assign dividend = NW'({adc_sample, {DIV_SHIFT{1'b0}}}) + NW'(pad_gain >> 1);
  assign div_hi   = dividend[NW-1:QBITS];
  assign div_ovf  = CMPW'(div_hi) >= CMPW'(pad_gain);

  // one restoring divide step
  logic [17:0] trial;
  logic        qbit;
  assign trial = {1'b0, div_rem, div_low[QBITS-1]} - {2'b00, gain_q};
  assign qbit  = !trial[17];

  // subtract rounded correction from the corrected sample, saturate
  logic signed [26:0] x_ext, rs_ext, diff;
  logic signed [AMP_BITS-1:0] r_sat;
  always_comb begin
    x_ext  = signed'({9'b0, div_low});
    rs_ext = signed'({corr_q[33], corr_q[33:8]});
    diff   = x_ext - rs_ext;
    if (diff > 27'sd262143) begin
      r_sat = 19'sh3FFFF;
    end else if (diff < -27'sd262144) begin
      r_sat = 19'sh40000;
    end else begin
      r_sat = diff[AMP_BITS-1:0];
    end
  end

  // lane datapath: radix-4 multiply step and final rounding
  logic signed [34:0] term     [2];
  logic signed [48:0] acc_step [2];
  logic signed [48:0] rnd_sum  [2];
  logic signed [32:0] n_wide   [2];
  logic signed [31:0] n_sat    [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (dig[l][15:14])
        2'd0:    term[l] = '0;
        2'd1:    term[l] = {{2{mcand[l][32]}}, mcand[l]};
        2'd2:    term[l] = {mcand[l][32], mcand[l], 1'b0};
        default: term[l] = m3[l];
      endcase
      acc_step[l] = (acc[l] <<< 2) + {{14{term[l][34]}}, term[l]};
      rnd_sum[l]  = acc[l] + 49'sd32768;
      n_wide[l]   = rnd_sum[l][48:16];
      if (n_wide[l][32] != n_wide[l][31]) begin
        n_sat[l] = n_wide[l][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        n_sat[l] = n_wide[l][31:0];
      end
    end
  end

  // threshold compare on the held result, signed
  logic above;
  assign above = !invalid_q &&
                 (signed'({r_q[AMP_BITS-1], r_q}) > signed'({4'b0, threshold, 6'b0}));

  assign in_ready = (state == ST_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tail_enable <= 1'b1;
      exp_count   <= 2'd2;
      threshold   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TAIL_ENABLE: tail_enable <= cfg_data[0];
        REG_EXP_COUNT:   exp_count   <= cfg_data[1:0];
        REG_THRESHOLD:   threshold   <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      rem[LANE_FAST] <= '0;
      rem[LANE_SLOW] <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (series_start) begin
              rem[LANE_FAST] <= '0;
              rem[LANE_SLOW] <= '0;
            end
            cnt <= CNT_BITS'(DIV_STEPS - 1);
            if (pad_gain == '0 || div_ovf) begin
              state <= ST_SUM;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_SUM;
          end
        end
        ST_SUM:  state <= ST_CORR;
        ST_CORR: begin
          if (filter_on) begin
            state <= ST_PREP1;
          end else begin
            rem[LANE_FAST] <= '0;
            rem[LANE_SLOW] <= '0;
            state <= ST_DONE;
          end
        end
        ST_PREP1: begin
          cnt   <= CNT_BITS'(MUL_STEPS - 1);
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_RND1;
          end
        end
        ST_RND1: state <= ST_ADDS;
        ST_ADDS: state <= ST_PREP2;
        ST_PREP2: begin
          cnt   <= CNT_BITS'(MUL_STEPS - 1);
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          rem[LANE_FAST] <= n_sat[LANE_FAST];
          rem[LANE_SLOW] <= two_exp ? n_sat[LANE_SLOW] : 32'sd0;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        gain_q    <= pad_gain;
        invalid_q <= (pad_gain == '0);
        div_rem   <= 16'(div_hi);
        if (pad_gain == '0) begin
          div_low <= '0;
        end else if (div_ovf) begin
          div_low <= '1;
        end else begin
          div_low <= dividend[QBITS-1:0];
        end
      end
      ST_DIV: begin
        div_rem <= qbit ? trial[15:0] : {div_rem[14:0], div_low[QBITS-1]};
        div_low <= {div_low[QBITS-2:0], qbit};
      end
      ST_SUM: begin
        corr_q <= {{2{rem[LANE_FAST][31]}}, rem[LANE_FAST]} +
                  (two_exp ? {{2{rem[LANE_SLOW][31]}}, rem[LANE_SLOW]} : 34'sd0) +
                  34'sd128;
      end
      ST_CORR: begin
        r_q <= filter_on ? r_sat : signed'({1'b0, div_low});
        mcand[LANE_FAST] <= {{14{r_sat[AMP_BITS-1]}}, r_sat};
        mcand[LANE_SLOW] <= {{14{r_sat[AMP_BITS-1]}}, r_sat};
      end
      ST_PREP1: begin
        dig[LANE_FAST] <= two_exp ? COEF_FAST : COEF_ONE;
        dig[LANE_SLOW] <= COEF_SLOW;
        for (int l = 0; l < 2; l++) begin
          m3[l]  <= {{2{mcand[l][32]}}, mcand[l]} + {mcand[l][32], mcand[l], 1'b0};
          acc[l] <= '0;
        end
      end
      ST_MUL1, ST_MUL2: begin
        for (int l = 0; l < 2; l++) begin
          acc[l] <= acc_step[l];
          dig[l] <= {dig[l][13:0], 2'b00};
        end
      end
      ST_RND1: begin
        for (int l = 0; l < 2; l++) begin
          acc[l] <= acc[l] + 49'sd128;
        end
      end
      ST_ADDS: begin
        dig[LANE_FAST] <= RATE_FAST;
        dig[LANE_SLOW] <= RATE_SLOW;
        for (int l = 0; l < 2; l++) begin
          mcand[l] <= {rem[l][31], rem[l]} + acc[l][40:8];
          acc[l]   <= '0;
        end
      end
      ST_PREP2: begin
        for (int l = 0; l < 2; l++) begin
          m3[l] <= {{2{mcand[l][32]}}, mcand[l]} + {mcand[l][32], mcand[l], 1'b0};
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          amplitude       <= above ? r_q : '0;
          above_threshold <= above;
          gain_invalid    <= invalid_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/gtc_checker.sv -----
// ----------------------------------------------------------------------------
// gtc_checker
// Port-level checks of the gain and tail cancellation filter, bound to it.
// ----------------------------------------------------------------------------
`include "gain_and_tail_cancellation_filter_defines.svh"

module gtc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [18:0] amplitude,
  input logic               above_threshold,
  input logic               gain_invalid
);

  // one word at a time: busy right after an accept
  `GTC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")

  // zero gain never reports an amplitude
  `GTC_ASSERT_NOW(a_invalid_zero, out_valid && gain_invalid, !above_threshold && amplitude == 19'sd0, "zero gain gave an amplitude")

  // below threshold reads zero
  `GTC_ASSERT_NOW(a_below_zero, out_valid && !above_threshold, amplitude == 19'sd0, "amplitude kept below threshold")

  // kept amplitudes are strictly positive
  `GTC_ASSERT_NOW(a_above_positive, out_valid && above_threshold, !amplitude[18] && amplitude != 19'sd0, "kept amplitude not positive")

  // stalled word holds
  `GTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(amplitude), "output word changed under stall")

endmodule

bind gain_and_tail_cancellation_filter gtc_checker u_gtc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .amplitude       (amplitude),
  .above_threshold (above_threshold),
  .gain_invalid    (gain_invalid)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain and tail cancellation filter testbench
// Drives pad time series through the filter with random idle gaps on both
// sides, predicts every result word in fixed point, and checks each word in
// order. Runs a directed set at reset settings, then random series under a
// sequence of register settings that covers the extremes.
// ----------------------------------------------------------------------------
module testbench;
  import gtc_pkg::*;

  localparam int SAMPLE_BITS = 10;

  // saturation bounds
  localparam longint AMP_HI = 262143;
  localparam longint AMP_LO = -262144;
  localparam longint REM_HI = 64'sh7FFF_FFFF;
  localparam longint REM_LO = -REM_HI - 1;

  // Q0.16 decay rates and tail weights
  localparam longint DECAY_FAST    = 60105;
  localparam longint DECAY_SLOW    = 30367;
  localparam longint WEIGHT_SINGLE = 4325;
  localparam longint WEIGHT_FAST   = 7471;
  localparam longint WEIGHT_SLOW   = 40894;

  typedef struct {
    logic [SAMPLE_BITS-1:0] adc;
    logic [GAIN_BITS-1:0]   gain;
    logic                   start;
  } sample_t;

  typedef struct {
    logic signed [AMP_BITS-1:0] amp;
    logic                       above;
    logic                       invalid;
  } result_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  logic [1:0]                  cfg_index = '0;
  logic [THR_BITS-1:0]         cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [SAMPLE_BITS-1:0]      adc_sample = '0;
  logic [GAIN_BITS-1:0]        pad_gain = '0;
  logic                        series_start = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [AMP_BITS-1:0]  amplitude;
  logic                        above_threshold;
  logic                        gain_invalid;

  // predictor copy of the registers and the tail remainders
  bit                  tail_on = 1'b1;
  bit [1:0]            exp_count = 2'd2;
  bit [THR_BITS-1:0]   thr_counts = '0;
  int                  fast_rem = 0;
  int                  slow_rem = 0;

  sample_t pending_samples[$];
  result_t predicted_results[$];
  result_t want_word;
  int      send_gap = 0;
  int      recv_stall = 0;
  int      mismatches = 0;
  bit      calm = 1'b0;

  gain_and_tail_cancellation_filter #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .adc_sample(adc_sample),
    .pad_gain(pad_gain),
    .series_start(series_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .amplitude(amplitude),
    .above_threshold(above_threshold),
    .gain_invalid(gain_invalid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(8_000_000);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // round half toward plus infinity, then drop s bits
  function automatic longint round_half_up(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic int decay_step(longint rem, longint rate, longint weight, longint r);
    longint feed;
    feed = round_half_up(weight * r, 8);
    return int'(clip(round_half_up(rate * (rem + feed), 16), REM_LO, REM_HI));
  endfunction

  function automatic result_t filter_sample(sample_t s);
    longint  g;
    longint  x;
    longint  r;
    longint  corr;
    int      lanes;
    result_t res;
    lanes = (exp_count >= 2) ? 2 : int'(exp_count);
    g = s.gain;
    x = 0;
    if (s.start) begin
      fast_rem = 0;
      slow_rem = 0;
    end
    // gain correction, zero gain reads as a zero sample
    if (g != 0) begin
      x = ((longint'(s.adc) <<< 20) + g / 2) / g;
      if (x > AMP_HI) x = AMP_HI;
    end
    if (!tail_on || lanes == 0) begin
      r = x;
      fast_rem = 0;
      slow_rem = 0;
    end else begin
      corr = fast_rem;
      if (lanes == 2) corr += slow_rem;
      r = clip(x - round_half_up(corr, 8), AMP_LO, AMP_HI);
      if (lanes == 1) begin
        fast_rem = decay_step(fast_rem, DECAY_FAST, WEIGHT_SINGLE, r);
        slow_rem = 0;
      end else begin
        fast_rem = decay_step(fast_rem, DECAY_FAST, WEIGHT_FAST, r);
        slow_rem = decay_step(slow_rem, DECAY_SLOW, WEIGHT_SLOW, r);
      end
    end
    res.invalid = (g == 0);
    res.above = (g != 0) && (r > longint'(thr_counts) * 64);
    res.amp = res.above ? r[AMP_BITS-1:0] : '0;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 100);
  endfunction

  function automatic void queue_sample(int adc, int gain, bit start);
    sample_t s;
    s.adc = SAMPLE_BITS'(adc);
    s.gain = GAIN_BITS'(gain);
    s.start = start;
    pending_samples.push_back(s);
  endfunction

  // pulse-shaped series with random content, plus some noise words
  task automatic queue_random(int count);
    int made;
    int len;
    int k;
    int peak_at;
    int base;
    int level;
    int kind;
    int gain;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 99) < 15) begin
        gain = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, 65535);
        queue_sample($urandom_range(0, 1023), gain, $urandom_range(0, 1));
        made++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(3, 16);
        kind = $urandom_range(0, 9);
        if (kind < 7) gain = $urandom_range(8192, 32768);
        else if (kind < 9) gain = $urandom_range(1, 65535);
        else gain = $urandom_range(1, 2000);
        base = $urandom_range(0, 30);
        peak_at = $urandom_range(0, len / 3);
        level = 0;
        for (k = 0; k < len; k++) begin
          if (k == peak_at) level = $urandom_range(0, 1023);
          else if (k > peak_at) level = level * int'($urandom_range(40, 90)) / 100;
          queue_sample((base + level > 1023) ? 1023 : base + level,
                       ($urandom_range(0, 32) == 0) ? 0 : gain, k == 0);
          made++;
        end
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [THR_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TAIL_ENABLE: tail_on = val[0];
      REG_EXP_COUNT:   exp_count = val[1:0];
      REG_THRESHOLD:   thr_counts = val;
      default: ;
    endcase
  endtask

  task automatic set_config(int enable, int count, int threshold);
    write_reg(REG_TAIL_ENABLE, THR_BITS'(enable));
    write_reg(REG_EXP_COUNT, THR_BITS'(count));
    write_reg(REG_THRESHOLD, THR_BITS'(threshold));
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_results.push_back(filter_sample(pending_samples.pop_front()));
        send_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          adc_sample <= pending_samples[0].adc;
          pad_gain <= pending_samples[0].gain;
          series_start <= pending_samples[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          mismatches++;
          $error("amplitude: no word expected, got %0d", amplitude);
        end else begin
          want_word = predicted_results.pop_front();
          if (amplitude !== want_word.amp) begin
            mismatches++;
            $error("amplitude: expected %0d, got %0d", want_word.amp, amplitude);
          end
          if (above_threshold !== want_word.above) begin
            mismatches++;
            $error("above_threshold: expected %0b, got %0b", want_word.above,
                   above_threshold);
          end
          if (gain_invalid !== want_word.invalid) begin
            mismatches++;
            $error("gain_invalid: expected %0b, got %0b", want_word.invalid, gain_invalid);
          end
        end
        recv_stall = pick_gap();
      end else if (recv_stall > 0) begin
        recv_stall--;
      end else if ($urandom_range(0, 19) == 0) begin
        // occasional stall, also when no word is waiting
        recv_stall = pick_gap();
      end
      out_ready <= (recv_stall == 0);
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int phase;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, field extremes, zero gain, series restarts
    queue_sample(0, 16384, 1);
    queue_sample(1023, 16384, 0);
    queue_sample(1023, 1, 0);
    queue_sample(1023, 65535, 0);
    queue_sample(1, 65535, 0);
    queue_sample(500, 0, 0);
    queue_sample(0, 0, 1);
    queue_sample(10, 16384, 1);
    queue_sample(600, 16384, 0);
    queue_sample(900, 16384, 0);
    queue_sample(700, 16384, 0);
    queue_sample(400, 16384, 0);
    queue_sample(200, 16384, 0);
    queue_sample(100, 16384, 0);
    queue_sample(50, 16384, 0);
    queue_sample(20, 16384, 0);
    queue_sample(10, 16384, 0);
    queue_sample(5, 16384, 0);
    queue_sample(0, 16384, 0);
    queue_sample(0, 16384, 0);
    // restart while the remainders are still large
    queue_sample(800, 12000, 1);
    queue_sample(300, 12000, 0);
    queue_sample(0, 12000, 0);
    wait_drained();

    // random series under a run of register settings
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_config(1, 1, 0);
        1: set_config(0, 2, 0);
        2: set_config(1, 0, 3);
        3: set_config(1, 3, 0);
        4: set_config(1, 2, 1023);
        5: set_config(0, 0, 1023);
        default: set_config($urandom_range(0, 1), $urandom_range(0, 3),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 40));
      endcase
      calm = (phase % 4 == 3);
      queue_random(65);
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
